// ===== sv/cdsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Calendar date arithmetic package
// Types, calendar constants, calendar helper functions and the control store
// of the date sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cdsa_pkg;

   localparam int YEAR_W   = 12;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int COUNT_W  = 21;
   localparam int SERIAL_W = 17;
   localparam int DIFF_W   = 18;
   localparam int OP_W     = 3;
   localparam int YOFF_W   = 8;
   localparam int WIDE_W   = 22;
   localparam int MAG_W    = 21;
   localparam int STEP_W   = 4;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 64;

   localparam logic [SERIAL_W-1:0] SPAN_DAYS  = 17'd73049;
   localparam logic [YEAR_W-1:0]   FIRST_YEAR = 12'd1900;
   localparam logic [YEAR_W-1:0]   LAST_YEAR  = 12'd2099;
   localparam logic [YOFF_W-1:0]   LAST_YOFF  = 8'd199;
   localparam logic [MONTH_W-1:0]  LAST_MONTH = 4'd12;
   localparam logic [MONTH_W-1:0]  FEBRUARY   = 4'd2;

   localparam logic [OP_W-1:0] OP_VALIDATE = 3'd0;
   localparam logic [OP_W-1:0] OP_FROM_CNT = 3'd1;
   localparam logic [OP_W-1:0] OP_ADD      = 3'd2;
   localparam logic [OP_W-1:0] OP_SUB      = 3'd3;
   localparam logic [OP_W-1:0] OP_COMPARE  = 3'd4;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } seq_state_type;

   typedef enum logic [3:0] {
      A_NOP,
      A_LOAD_P,
      A_SER_P,
      A_COUNT,
      A_MODSUB,
      A_FINAL_S,
      A_LOAD_O,
      A_SER_O,
      A_CMP,
      A_INIT_DATE,
      A_YEAR,
      A_MONTH,
      A_DONE
   } action_type;

   typedef enum logic [2:0] {
      J_NONE,
      J_ALWAYS,
      J_OP_CMP,
      J_OP_PASS,
      J_MAG_GE,
      J_YEAR_MORE,
      J_MONTH_MORE,
      J_OUT_BUSY
   } cond_type;

   typedef struct packed {
      action_type        action;
      cond_type          cond;
      logic [STEP_W-1:0] target;
   } ucode_type;

   localparam logic [STEP_W-1:0] STEP_START  = 4'd0;
   localparam logic [STEP_W-1:0] STEP_MODSUB = 4'd5;
   localparam logic [STEP_W-1:0] STEP_CMP    = 4'd7;
   localparam logic [STEP_W-1:0] STEP_DATE   = 4'd10;
   localparam logic [STEP_W-1:0] STEP_YEAR   = 4'd11;
   localparam logic [STEP_W-1:0] STEP_MONTH  = 4'd12;
   localparam logic [STEP_W-1:0] STEP_DONE   = 4'd13;

   function automatic ucode_type ucode_at(input logic [STEP_W-1:0] step);
      ucode_type uc;
      case (step)
         4'd0:    uc = '{A_LOAD_P,    J_NONE,       STEP_START};
         4'd1:    uc = '{A_SER_P,     J_NONE,       STEP_START};
         4'd2:    uc = '{A_NOP,       J_OP_CMP,     STEP_CMP};
         4'd3:    uc = '{A_NOP,       J_OP_PASS,    STEP_DATE};
         4'd4:    uc = '{A_COUNT,     J_NONE,       STEP_START};
         4'd5:    uc = '{A_MODSUB,    J_MAG_GE,     STEP_MODSUB};
         4'd6:    uc = '{A_FINAL_S,   J_ALWAYS,     STEP_DATE};
         4'd7:    uc = '{A_LOAD_O,    J_NONE,       STEP_START};
         4'd8:    uc = '{A_SER_O,     J_NONE,       STEP_START};
         4'd9:    uc = '{A_CMP,       J_NONE,       STEP_START};
         4'd10:   uc = '{A_INIT_DATE, J_NONE,       STEP_START};
         4'd11:   uc = '{A_YEAR,      J_YEAR_MORE,  STEP_YEAR};
         4'd12:   uc = '{A_MONTH,     J_MONTH_MORE, STEP_MONTH};
         default: uc = '{A_DONE,      J_OUT_BUSY,   STEP_DONE};
      endcase
      return uc;
   endfunction

   // Year offsets count from 1900; 1900 is not a leap year, 2000 is.
   function automatic logic is_leap(input logic [YOFF_W-1:0] yoff);
      return (yoff[1:0] == 2'b00) && (yoff != '0);
   endfunction

   function automatic logic [DAY_W-1:0] month_days(input logic [YOFF_W-1:0] yoff,
                                                   input logic [MONTH_W-1:0] month);
      logic [DAY_W-1:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                      len = 5'd30;
         4'd2:    len = 5'd28 + DAY_W'(is_leap(yoff));
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] month);
      logic [8:0] cum;
      case (month)
         4'd2:    cum = 9'd31;
         4'd3:    cum = 9'd59;
         4'd4:    cum = 9'd90;
         4'd5:    cum = 9'd120;
         4'd6:    cum = 9'd151;
         4'd7:    cum = 9'd181;
         4'd8:    cum = 9'd212;
         4'd9:    cum = 9'd243;
         4'd10:   cum = 9'd273;
         4'd11:   cum = 9'd304;
         4'd12:   cum = 9'd334;
         default: cum = 9'd0;
      endcase
      return cum;
   endfunction

   function automatic logic date_ok(input logic [YEAR_W-1:0]  year,
                                    input logic [MONTH_W-1:0] month,
                                    input logic [DAY_W-1:0]   day);
      logic [YEAR_W-1:0] yoff;
      yoff = year - FIRST_YEAR;
      return (year >= FIRST_YEAR) && (year <= LAST_YEAR) &&
             (month >= 4'd1) && (month <= LAST_MONTH) && (day >= 5'd1) &&
             (day <= month_days(yoff[YOFF_W-1:0], month));
   endfunction

   function automatic logic [SERIAL_W-1:0] serial_of(input logic [YOFF_W-1:0]  yoff,
                                                     input logic [MONTH_W-1:0] month,
                                                     input logic [DAY_W-1:0]   day);
      logic [SERIAL_W-1:0] years;
      logic [YOFF_W:0]     leaps;
      logic                adj;
      years = SERIAL_W'(yoff) * 17'd365;
      leaps = ((YOFF_W+1)'(yoff) + 9'd3) >> 2;
      leaps = leaps - (YOFF_W+1)'(yoff != '0);
      adj   = (month > FEBRUARY) && is_leap(yoff);
      return years + SERIAL_W'(leaps) + SERIAL_W'(days_before_month(month)) +
             SERIAL_W'(adj) + SERIAL_W'(day);
   endfunction

endpackage

`default_nettype wire

// ===== sv/calendar_date_serial_arithmetic.sv =====
// ----------------------------------------------------------------------------
// Calendar date serial arithmetic
// Validates dates in 1900..2099, converts counts and dates to serial days,
// adds, subtracts and compares, driven by a small microcoded sequencer.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake             | Content
//  req     | in        | req_tvalid/req_tready | opcode in tuser, dates and count
//  rsp     | out       | rsp_tvalid/rsp_tready | result date, serial, comparison
//
//  One word is worked on at a time; a new request is taken once the previous
//  one has reached the output register. The time a word takes is set mostly
//  by the year loop, which steps one year per cycle. Reset clears the
//  sequencer and the output valid. A stalled output only holds the
//  sequencer in its last step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_serial_arithmetic (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // opcode
   input  wire logic [cdsa_pkg::OP_W-1:0]          req_tuser,
   // in_year, in_month, in_day, day_count, other_year, other_month, other_day
   input  wire logic [cdsa_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // out_year, out_month, out_day, serial_day, difference, is_greater, is_equal
   output logic [cdsa_pkg::RSP_DATA_W-1:0]         rsp_tdata
);
   import cdsa_pkg::*;

   seq_state_type             state_ff, state_in;
   logic [STEP_W-1:0]         pc_ff, pc_in;
   ucode_type                 uc;
   logic                      jump;
   logic                      req_fire;
   logic                      out_busy;
   logic                      done_fire;

   logic [OP_W-1:0]           op_ff;
   logic [YEAR_W-1:0]         pri_y_ff, oth_y_ff;
   logic [MONTH_W-1:0]        pri_m_ff, oth_m_ff;
   logic [DAY_W-1:0]          pri_d_ff, oth_d_ff;
   logic signed [COUNT_W-1:0] cnt_ff;

   logic [YOFF_W-1:0]         yoff_ff, yoff_in;
   logic [MONTH_W-1:0]        mo_ff, mo_in;
   logic [DAY_W-1:0]          dy_ff, dy_in;
   logic [SERIAL_W-1:0]       s_ff, s_in;
   logic [SERIAL_W-1:0]       s2_ff, s2_in;
   logic [SERIAL_W-1:0]       rem_ff, rem_in;
   logic [MAG_W-1:0]          mag_ff, mag_in;
   logic                      neg_ff, neg_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic                      gt_ff, gt_in;
   logic                      eq_ff, eq_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   logic [YEAR_W-1:0]         src_y;
   logic [MONTH_W-1:0]        src_m;
   logic [DAY_W-1:0]          src_d;
   logic [YEAR_W-1:0]         src_yoff;
   logic [SERIAL_W-1:0]       ser_now;
   logic signed [WIDE_W-1:0]  base_w, cnt_w, n_w, abs_w;
   logic [SERIAL_W-1:0]       year_len;
   logic                      year_more;
   logic                      month_more;
   logic                      mag_ge;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_busy   = rsp_valid_ff && !rsp_tready;
   assign uc         = ucode_at(pc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= STEP_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_tuser;
         pri_y_ff <= req_tdata[11:0];
         pri_m_ff <= req_tdata[15:12];
         pri_d_ff <= req_tdata[20:16];
         cnt_ff   <= signed'(req_tdata[41:21]);
         oth_y_ff <= req_tdata[53:42];
         oth_m_ff <= req_tdata[57:54];
         oth_d_ff <= req_tdata[62:58];
      end
      yoff_ff     <= yoff_in;
      mo_ff       <= mo_in;
      dy_ff       <= dy_in;
      s_ff        <= s_in;
      s2_ff       <= s2_in;
      rem_ff      <= rem_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      diff_ff     <= diff_in;
      gt_ff       <= gt_in;
      eq_ff       <= eq_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      if (uc.action == A_LOAD_O) begin
         src_y = oth_y_ff;
         src_m = oth_m_ff;
         src_d = oth_d_ff;
      end else begin
         src_y = pri_y_ff;
         src_m = pri_m_ff;
         src_d = pri_d_ff;
      end
      src_yoff   = src_y - FIRST_YEAR;
      ser_now    = serial_of(yoff_ff, mo_ff, dy_ff);
      base_w     = (op_ff == OP_FROM_CNT) ? '0 : signed'(WIDE_W'(s_ff));
      cnt_w      = WIDE_W'(cnt_ff);
      n_w        = ((op_ff == OP_SUB) ? (base_w - cnt_w) : (base_w + cnt_w)) - 22'sd1;
      abs_w      = n_w[WIDE_W-1] ? -n_w : n_w;
      year_len   = 17'd365 + SERIAL_W'(is_leap(yoff_ff));
      year_more  = (yoff_ff < LAST_YOFF) && (rem_ff > year_len);
      month_more = (mo_ff < LAST_MONTH) &&
                   (rem_ff > SERIAL_W'(month_days(yoff_ff, mo_ff)));
      mag_ge     = (mag_ff >= MAG_W'(SPAN_DAYS));
   end

   always_comb begin
      case (uc.cond)
         J_NONE:       jump = 1'b0;
         J_ALWAYS:     jump = 1'b1;
         J_OP_CMP:     jump = (op_ff == OP_COMPARE);
         J_OP_PASS:    jump = (op_ff == OP_VALIDATE) || (op_ff > OP_COMPARE);
         J_MAG_GE:     jump = mag_ge;
         J_YEAR_MORE:  jump = year_more;
         J_MONTH_MORE: jump = month_more;
         J_OUT_BUSY:   jump = out_busy;
         default:      jump = 1'b0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      done_fire    = 1'b0;
      yoff_in      = yoff_ff;
      mo_in        = mo_ff;
      dy_in        = dy_ff;
      s_in         = s_ff;
      s2_in        = s2_ff;
      rem_in       = rem_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      diff_in      = diff_ff;
      gt_in        = gt_ff;
      eq_in        = eq_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;

      case (state_ff)
         ST_IDLE: begin
            pc_in = STEP_START;
            if (req_fire) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            pc_in = jump ? uc.target : pc_ff + 4'd1;
            case (uc.action)
               A_LOAD_P, A_LOAD_O: begin
                  if (date_ok(src_y, src_m, src_d)) begin
                     yoff_in = src_yoff[YOFF_W-1:0];
                     mo_in   = src_m;
                     dy_in   = src_d;
                  end else begin
                     yoff_in = '0;
                     mo_in   = 4'd1;
                     dy_in   = 5'd1;
                  end
                  if (uc.action == A_LOAD_P) begin
                     diff_in = '0;
                     gt_in   = 1'b0;
                     eq_in   = 1'b0;
                  end
               end
               A_SER_P: s_in  = ser_now;
               A_SER_O: s2_in = ser_now;
               A_COUNT: begin
                  mag_in = abs_w[MAG_W-1:0];
                  neg_in = n_w[WIDE_W-1] && (abs_w < WIDE_W'(SPAN_DAYS));
               end
               A_MODSUB: begin
                  if (mag_ge) begin
                     mag_in = mag_ff - MAG_W'(SPAN_DAYS);
                  end
               end
               A_FINAL_S: begin
                  if (neg_ff) begin
                     s_in = SERIAL_W'(MAG_W'(SPAN_DAYS) + 21'd1 - mag_ff);
                  end else begin
                     s_in = SERIAL_W'(mag_ff + 21'd1);
                  end
               end
               A_CMP: begin
                  diff_in = signed'(DIFF_W'(s_ff)) - signed'(DIFF_W'(s2_ff));
                  gt_in   = (s_ff > s2_ff);
                  eq_in   = (s_ff == s2_ff);
               end
               A_INIT_DATE: begin
                  yoff_in = '0;
                  mo_in   = 4'd1;
                  rem_in  = s_ff;
               end
               A_YEAR: begin
                  if (year_more) begin
                     rem_in  = rem_ff - year_len;
                     yoff_in = yoff_ff + 8'd1;
                  end
               end
               A_MONTH: begin
                  if (month_more) begin
                     rem_in = rem_ff - SERIAL_W'(month_days(yoff_ff, mo_ff));
                     mo_in  = mo_ff + 4'd1;
                  end
               end
               A_DONE: begin
                  if (!out_busy) begin
                     done_fire = 1'b1;
                     state_in  = ST_IDLE;
                     pc_in     = STEP_START;
                  end
               end
               default: ;
            endcase
         end
         default: begin
            state_in = ST_IDLE;
            pc_in    = STEP_START;
         end
      endcase

      if (done_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, eq_ff, gt_ff, diff_ff, s_ff, rem_ff[DAY_W-1:0], mo_ff,
                         YEAR_W'(yoff_ff) + FIRST_YEAR};
      end
   end

endmodule

`default_nettype wire

// ===== sv/cdsa_checker.sv =====
// ----------------------------------------------------------------------------
// Calendar date arithmetic checker
// Port-level checks on the request and response channels, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdsa_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [cdsa_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import cdsa_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a word is in work");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[11:0] >= FIRST_YEAR) && (rsp_tdata[11:0] <= LAST_YEAR) &&
                     (rsp_tdata[15:12] >= 4'd1) && (rsp_tdata[15:12] <= LAST_MONTH) &&
                     (rsp_tdata[20:16] != 5'd0) && (rsp_tdata[37:21] != 17'd0) &&
                     (rsp_tdata[37:21] <= SPAN_DAYS))
      else $error("response date out of span");

   a_compare_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[56] && rsp_tdata[57]) &&
                     (rsp_tdata[57] == (rsp_tdata[56] == 1'b0 && rsp_tdata[57] == 1'b1)) &&
                     (!rsp_tdata[57] || rsp_tdata[55:38] == 18'd0) &&
                     (!rsp_tdata[56] || rsp_tdata[55] == 1'b0))
      else $error("compare flags disagree with difference");

endmodule

bind calendar_date_serial_arithmetic cdsa_checker u_cdsa_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Calendar date serial arithmetic testbench
// Sends request words that carry an opcode, a primary date, a day count and a
// second date, and checks each response word against a calendar predictor that
// works through the Gregorian years and months one at a time. A short table of
// edge cases comes first, followed by random words. The sender runs in bursts
// with random gaps, and the receiver changes its stall pattern as it goes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
   import cdsa_pkg::*;

   localparam int RANDOM_WORDS = 650;
   localparam int DRAIN_CYCLES = 300;
   localparam int LIMIT_CYCLES = 2000000;
   localparam int DAY_SPAN     = 73049;
   localparam int YEAR_FIRST   = 1900;
   localparam int YEAR_LAST    = 2099;

   // Opcodes with no operation of their own; the block treats them as validate.
   localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

   typedef struct {
      logic [OP_W-1:0]           op;
      logic [YEAR_W-1:0]         year;
      logic [MONTH_W-1:0]        month;
      logic [DAY_W-1:0]          day;
      logic signed [COUNT_W-1:0] count;
      logic [YEAR_W-1:0]         oyear;
      logic [MONTH_W-1:0]        omonth;
      logic [DAY_W-1:0]          oday;
   } date_req_type;

   typedef struct {
      logic [YEAR_W-1:0]        year;
      logic [MONTH_W-1:0]       month;
      logic [DAY_W-1:0]         day;
      logic [SERIAL_W-1:0]      serial;
      logic signed [DIFF_W-1:0] diff;
      logic                     gt;
      logic                     eq;
   } date_rsp_type;

   typedef struct {
      date_req_type stim;
      bit           typed;
      date_rsp_type want;
   } table_row_type;

   typedef enum {
      READY_ALWAYS,
      READY_COIN,
      READY_BURSTS
   } ready_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [OP_W-1:0]       req_tuser = '0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   date_rsp_type   pending_results[$];
   table_row_type  edge_table[$];
   int             mismatches = 0;
   int             results_checked = 0;
   int             words_sent = 0;
   int             op_seen[8];
   int             burst_left = 0;
   int             cycle_count = 0;
   int             stall_left = 0;
   int             mode_left = 0;
   ready_mode_type ready_mode = READY_ALWAYS;
   logic           next_ready;
   date_rsp_type   got_rsp;
   date_rsp_type   want_rsp;

   calendar_date_serial_arithmetic uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic bit greg_leap(input int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int month_length(input int y, input int m);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return 28 + int'(greg_leap(y));
         default:               return 0;
      endcase
   endfunction

   function automatic bit real_date(input int y, input int m, input int d);
      return (y >= YEAR_FIRST) && (y <= YEAR_LAST) && (m >= 1) && (m <= 12) &&
             (d >= 1) && (d <= month_length(y, m));
   endfunction

   function automatic int serial_from_date(input int y, input int m, input int d);
      int s;
      s = d;
      for (int t = YEAR_FIRST; t < y; t++) s += 365 + int'(greg_leap(t));
      for (int t = 1; t < m; t++) s += month_length(y, t);
      return s;
   endfunction

   function automatic int wrap_count(input longint v);
      longint n;
      n = v - 1;
      if (n >= DAY_SPAN || n <= -DAY_SPAN) begin
         if (n < 0) n = -n;
         n = n % DAY_SPAN;
      end
      if (n >= 0) return int'(n + 1);
      return int'(DAY_SPAN + 1 + n);
   endfunction

   function automatic void date_from_serial(input int s, output int y, output int m,
                                            output int d);
      y = YEAR_FIRST;
      m = 1;
      while (y < YEAR_LAST && s > 365 + int'(greg_leap(y))) begin
         s -= 365 + int'(greg_leap(y));
         y++;
      end
      while (m < 12 && s > month_length(y, m)) begin
         s -= month_length(y, m);
         m++;
      end
      d = s;
   endfunction

   function automatic date_rsp_type predict_date_result(input date_req_type r);
      date_rsp_type res;
      int           y, m, d, oy, om, od, s, s2;
      longint       c;
      y = int'(r.year);
      m = int'(r.month);
      d = int'(r.day);
      oy = int'(r.oyear);
      om = int'(r.omonth);
      od = int'(r.oday);
      c = longint'(r.count);
      res.diff = '0;
      res.gt = 1'b0;
      res.eq = 1'b0;
      if (!real_date(y, m, d)) begin
         y = YEAR_FIRST;
         m = 1;
         d = 1;
      end
      s = serial_from_date(y, m, d);
      case (r.op)
         OP_FROM_CNT: s = wrap_count(c);
         OP_ADD:      s = wrap_count(s + c);
         OP_SUB:      s = wrap_count(s - c);
         OP_COMPARE: begin
            if (!real_date(oy, om, od)) begin
               oy = YEAR_FIRST;
               om = 1;
               od = 1;
            end
            s2 = serial_from_date(oy, om, od);
            res.diff = DIFF_W'(s - s2);
            res.gt = (s > s2);
            res.eq = (s == s2);
         end
         default: ;
      endcase
      date_from_serial(s, y, m, d);
      res.year = YEAR_W'(y);
      res.month = MONTH_W'(m);
      res.day = DAY_W'(d);
      res.serial = SERIAL_W'(s);
      return res;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_request(input date_req_type r);
      return {1'b0, r.oday, r.omonth, r.oyear, r.count, r.day, r.month, r.year};
   endfunction

   task automatic add_row(input logic [OP_W-1:0] op, input int y, input int m, input int d,
                          input int cnt, input int oy, input int om, input int od,
                          input bit typed = 1'b0, input int wy = 0, input int wm = 0,
                          input int wd = 0, input int ws = 0, input int wdiff = 0,
                          input int wgt = 0, input int weq = 0);
      table_row_type row;
      row.stim = '{op, y[YEAR_W-1:0], m[MONTH_W-1:0], d[DAY_W-1:0], cnt[COUNT_W-1:0],
                   oy[YEAR_W-1:0], om[MONTH_W-1:0], od[DAY_W-1:0]};
      row.typed = typed;
      row.want = '{wy[YEAR_W-1:0], wm[MONTH_W-1:0], wd[DAY_W-1:0], ws[SERIAL_W-1:0],
                   wdiff[DIFF_W-1:0], wgt[0], weq[0]};
      edge_table.push_back(row);
   endtask

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got_v,
                              input logic [31:0] want_v);
      if (got_v !== want_v)
         report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got_v, want_v));
   endtask

   // Sends one word and files its expected result once the block takes it.
   task automatic send_word(input date_req_type r, input bit typed, input date_rsp_type want);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 2) == 0) gap = 0;
         else if ($urandom_range(0, 9) == 0) gap = $urandom_range(100, 200);
         else gap = $urandom_range(1, 40);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.op;
      req_tdata <= pack_request(r);
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(typed ? want : predict_date_result(r));
      op_seen[r.op]++;
      words_sent++;
      burst_left--;
   endtask

   task automatic pick_date(output logic [YEAR_W-1:0] y, output logic [MONTH_W-1:0] m,
                            output logic [DAY_W-1:0] d);
      int sel, yy, mm;
      sel = $urandom_range(0, 19);
      if (sel < 15) begin
         if (sel == 0) yy = YEAR_FIRST;
         else if (sel == 1) yy = YEAR_LAST;
         else yy = $urandom_range(YEAR_FIRST, YEAR_LAST);
         mm = $urandom_range(1, 12);
         y = YEAR_W'(yy);
         m = MONTH_W'(mm);
         d = DAY_W'($urandom_range(1, month_length(yy, mm)));
      end else if (sel < 17) begin
         y = YEAR_W'($urandom);
         m = MONTH_W'($urandom);
         d = DAY_W'($urandom);
      end else begin
         y = YEAR_W'($urandom_range(YEAR_FIRST - 5, YEAR_LAST + 5));
         m = MONTH_W'($urandom_range(0, 13));
         d = DAY_W'($urandom_range(0, 31));
      end
   endtask

   task automatic pick_word(output date_req_type r);
      int sel;
      sel = $urandom_range(0, 19);
      if (sel < 18) r.op = OP_W'(sel % 5);
      else r.op = OP_W'($urandom_range(OP_SPARE_5, OP_SPARE_7));
      pick_date(r.year, r.month, r.day);
      sel = $urandom_range(0, 9);
      if (sel < 4) r.count = COUNT_W'(int'($urandom_range(0, 800)) - 400);
      else if (sel < 7) r.count = COUNT_W'(int'($urandom_range(0, 160000)) - 80000);
      else r.count = COUNT_W'($urandom);
      if ($urandom_range(0, 3) == 0) begin
         r.oyear = r.year;
         r.omonth = r.month;
         r.oday = r.day;
      end else begin
         pick_date(r.oyear, r.omonth, r.oday);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
                  pending_results.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rsp.year = rsp_tdata[11:0];
         got_rsp.month = rsp_tdata[15:12];
         got_rsp.day = rsp_tdata[20:16];
         got_rsp.serial = rsp_tdata[37:21];
         got_rsp.diff = rsp_tdata[55:38];
         got_rsp.gt = rsp_tdata[56];
         got_rsp.eq = rsp_tdata[57];
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("response word 0x%0h with no request pending",
                                      rsp_tdata));
         end else begin
            want_rsp = pending_results.pop_front();
            check_field("out_year", 32'(got_rsp.year), 32'(want_rsp.year));
            check_field("out_month", 32'(got_rsp.month), 32'(want_rsp.month));
            check_field("out_day", 32'(got_rsp.day), 32'(want_rsp.day));
            check_field("serial_day", 32'(got_rsp.serial), 32'(want_rsp.serial));
            check_field("difference", 32'(got_rsp.diff), 32'(want_rsp.diff));
            check_field("is_greater", 32'(got_rsp.gt), 32'(want_rsp.gt));
            check_field("is_equal", 32'(got_rsp.eq), 32'(want_rsp.eq));
         end
         results_checked++;
      end
      mode_left = mode_left - 1;
      if (mode_left <= 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 2));
         mode_left = $urandom_range(50, 400);
      end
      if (stall_left > 0) begin
         stall_left--;
         next_ready = 1'b0;
      end else begin
         case (ready_mode)
            READY_ALWAYS: next_ready = 1'b1;
            READY_COIN:   next_ready = 1'($urandom_range(0, 1));
            default: begin
               if ($urandom_range(0, 24) == 0) begin
                  stall_left = $urandom_range(1, 60);
                  next_ready = 1'b0;
               end else begin
                  next_ready = 1'b1;
               end
            end
         endcase
      end
      rsp_tready <= next_ready;
   end

   initial begin
      date_req_type r;
      date_rsp_type unused_rsp;
      unused_rsp = '{'0, '0, '0, '0, '0, 1'b0, 1'b0};

      // Span ends, invalid dates, spare opcodes, count wrapping and compares.
      add_row(OP_VALIDATE, 1900, 1, 1, 0, 0, 0, 0, 1, 1900, 1, 1, 1);
      add_row(OP_VALIDATE, 2099, 12, 31, 0, 0, 0, 0, 1, 2099, 12, 31, 73049);
      add_row(OP_VALIDATE, 1899, 12, 31, 0, 0, 0, 0, 1, 1900, 1, 1, 1);
      add_row(OP_VALIDATE, 2100, 1, 1, 0, 0, 0, 0, 1, 1900, 1, 1, 1);
      add_row(OP_SPARE_7, 4095, 15, 31, -1, 4095, 15, 31, 1, 1900, 1, 1, 1);
      add_row(OP_VALIDATE, 2000, 0, 10, 0, 0, 0, 0, 1, 1900, 1, 1, 1);
      add_row(OP_VALIDATE, 2000, 5, 0, 0, 0, 0, 0, 1, 1900, 1, 1, 1);
      add_row(OP_VALIDATE, 1900, 2, 29, 0, 0, 0, 0, 1, 1900, 1, 1, 1);
      add_row(OP_VALIDATE, 2000, 2, 29, 0, 0, 0, 0);
      add_row(OP_VALIDATE, 2001, 4, 31, 0, 0, 0, 0, 1, 1900, 1, 1, 1);
      add_row(OP_SPARE_5, 2099, 12, 31, 0, 0, 0, 0, 1, 2099, 12, 31, 73049);
      add_row(OP_FROM_CNT, 0, 0, 0, 1, 0, 0, 0, 1, 1900, 1, 1, 1);
      add_row(OP_FROM_CNT, 0, 0, 0, 73049, 0, 0, 0, 1, 2099, 12, 31, 73049);
      add_row(OP_FROM_CNT, 0, 0, 0, 0, 0, 0, 0, 1, 2099, 12, 31, 73049);
      add_row(OP_FROM_CNT, 0, 0, 0, 73050, 0, 0, 0, 1, 1900, 1, 1, 1);
      add_row(OP_FROM_CNT, 0, 0, 0, -73048, 0, 0, 0, 1, 1900, 1, 1, 1);
      add_row(OP_FROM_CNT, 0, 0, 0, 1048575, 0, 0, 0);
      add_row(OP_FROM_CNT, 0, 0, 0, -1048576, 0, 0, 0);
      add_row(OP_ADD, 2099, 12, 31, 1, 0, 0, 0, 1, 1900, 1, 1, 1);
      add_row(OP_SUB, 1900, 1, 1, 1, 0, 0, 0, 1, 2099, 12, 31, 73049);
      add_row(OP_ADD, 2000, 2, 28, 1, 0, 0, 0);
      add_row(OP_SUB, 2024, 3, 1, 1, 0, 0, 0);
      add_row(OP_COMPARE, 1900, 1, 1, 0, 1900, 1, 1, 1, 1900, 1, 1, 1, 0, 0, 1);
      add_row(OP_COMPARE, 2099, 12, 31, 0, 1900, 1, 1, 1, 2099, 12, 31, 73049, 73048, 1, 0);
      add_row(OP_COMPARE, 1900, 1, 1, 0, 2099, 12, 31, 1, 1900, 1, 1, 1, -73048, 0, 0);
      add_row(OP_COMPARE, 2000, 3, 1, 0, 2000, 13, 1);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (edge_table[i]) send_word(edge_table[i].stim, edge_table[i].typed,
                                        edge_table[i].want);
      repeat (RANDOM_WORDS) begin
         pick_word(r);
         send_word(r, 1'b0, unused_rsp);
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d words (%0d from the edge table): validate %0d, from count %0d,",
               words_sent, edge_table.size(), op_seen[OP_VALIDATE], op_seen[OP_FROM_CNT]);
      $display("add %0d, subtract %0d, compare %0d, spare opcodes %0d; %0d results, %0d bad.",
               op_seen[OP_ADD], op_seen[OP_SUB], op_seen[OP_COMPARE],
               op_seen[OP_SPARE_5] + op_seen[OP_SPARE_6] + op_seen[OP_SPARE_7],
               results_checked, mismatches);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== calendar_date_serial_arithmetic.f =====
sv/cdsa_pkg.sv
sv/calendar_date_serial_arithmetic.sv
sv/cdsa_checker.sv
tb/testbench.sv
